/* design/hkse_pkg.sv */
// ----------------------------------------------------------------------------
// hkse_pkg
// Types and constants shared by the hex keypad scan/entry block.
// ----------------------------------------------------------------------------
package hkse_pkg;

  // Row nibble patterns (active low, one row pulled down)
  localparam logic [3:0] ROWS_IDLE  = 4'hF;
  localparam logic [3:0] ROW0_LOW   = 4'hE;
  localparam logic [3:0] ROW1_LOW   = 4'hD;
  localparam logic [3:0] ROW2_LOW   = 4'hB;
  localparam logic [3:0] ROW3_LOW   = 4'h7;

  // Confirm nibble value that means the confirm key is held
  localparam logic [3:0] CONFIRM_HELD = 4'hE;

  // Key code of the confirm key
  localparam logic [4:0] CONFIRM_CODE = 5'd16;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_HOLD_THRESHOLD       = 2'd0;
  localparam logic [1:0] REG_DIGIT_REPEAT_DELAY   = 2'd1;
  localparam logic [1:0] REG_CONFIRM_REPEAT_DELAY = 2'd2;

  // Register reset values
  localparam logic [3:0] HOLD_THRESHOLD_RST       = 4'd2;
  localparam logic [6:0] DIGIT_REPEAT_DELAY_RST   = 7'd20;
  localparam logic [6:0] CONFIRM_REPEAT_DELAY_RST = 7'd100;

  typedef struct packed {
    logic [3:0] row_levels;
    logic [3:0] confirm_levels;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  column_drive;
    logic        key_valid;
    logic [4:0]  key_code;
    logic        number_valid;
    logic [15:0] number_value;
  } out_item_t;

  // Classified tick handed from the front end to the back end
  typedef struct packed {
    logic [3:0] column_drive;
    logic       key_press;
    logic [3:0] key_digit;
    logic       release_hold;
    logic       confirm_press;
  } cmd_t;

  typedef struct packed {
    logic [3:0] hold_threshold;
    logic [6:0] digit_repeat_delay;
    logic [6:0] confirm_repeat_delay;
  } cfg_t;

  // Active-low drive pattern of a column
  function automatic logic [3:0] col_pattern(input logic [1:0] col);
    logic [3:0] pat;
    unique case (col)
      2'd0:    pat = 4'h7;
      2'd1:    pat = 4'hB;
      2'd2:    pat = 4'hD;
      default: pat = 4'hE;
    endcase
    return pat;
  endfunction

endpackage

/* design/hkse_fifo.sv */
// ----------------------------------------------------------------------------
// hkse_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module hkse_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/hkse_front.sv */
// ----------------------------------------------------------------------------
// hkse_front
// Scan front end: tracks the driven column, decodes the row nibble and
// classifies each tick into a press, a release or nothing, and flags the confirm key.
// ----------------------------------------------------------------------------
module hkse_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  hkse_pkg::in_item_t item,
  output hkse_pkg::cmd_t   cmd
);
  import hkse_pkg::*;

  logic [1:0] scan_col_r, scan_col_nxt;
  logic       held_col_vld_r, held_col_vld_nxt;
  logic [1:0] held_col_r, held_col_nxt;
  logic [1:0] row_idx;
  logic [1:0] col_inv;

  assign col_inv      = 2'd3 - scan_col_r;
  assign scan_col_nxt = scan_col_r + 2'd1;

  // Single low row gives its index; several low rows decode as key 0
  always_comb begin
    unique case (item.row_levels)
      ROW0_LOW: row_idx = 2'd0;
      ROW1_LOW: row_idx = 2'd1;
      ROW2_LOW: row_idx = 2'd2;
      ROW3_LOW: row_idx = 2'd3;
      default:  row_idx = 2'd0;
    endcase
  end

  always_comb begin
    cmd               = '0;
    held_col_vld_nxt  = held_col_vld_r;
    held_col_nxt      = held_col_r;
    cmd.column_drive  = col_pattern(scan_col_nxt);
    cmd.confirm_press = (item.confirm_levels == CONFIRM_HELD);
    if (item.row_levels != ROWS_IDLE) begin
      cmd.key_press    = 1'b1;
      held_col_vld_nxt = 1'b1;
      held_col_nxt     = scan_col_r;
      if ((item.row_levels == ROW0_LOW) || (item.row_levels == ROW1_LOW) ||
          (item.row_levels == ROW2_LOW) || (item.row_levels == ROW3_LOW)) begin
        cmd.key_digit = {row_idx, col_inv};
      end
    end else if (held_col_vld_r && (held_col_r == scan_col_r)) begin
      cmd.release_hold = 1'b1;
      held_col_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r     <= '0;
      held_col_vld_r <= 1'b0;
      held_col_r     <= '0;
    end else if (accept) begin
      scan_col_r     <= scan_col_nxt;
      held_col_vld_r <= held_col_vld_nxt;
      held_col_r     <= held_col_nxt;
    end
  end

endmodule

/* design/hkse_back.sv */
// ----------------------------------------------------------------------------
// hkse_back
// Back end: hold qualification with auto-repeat for keypad and confirm key,
// and hex number entry.
// ----------------------------------------------------------------------------
module hkse_back #(
  parameter int unsigned NUMBER_DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  hkse_pkg::cmd_t    cmd,
  input  hkse_pkg::cfg_t    cfg,
  output hkse_pkg::out_item_t result
);
  import hkse_pkg::*;

  localparam int unsigned LW = $clog2(NUMBER_DIGITS + 1);
  localparam logic [LW-1:0]   DIGITS     = LW'(NUMBER_DIGITS);
  localparam logic [LW+1:0]   SLOT_LIMIT = (LW + 2)'(4);

  logic              held_key_vld_r, held_key_vld_nxt;
  logic [4:0]        held_key_r, held_key_nxt;
  logic signed [7:0] hold_ticks_r, hold_ticks_nxt;
  logic [15:0]       entry_r, entry_nxt;
  logic [LW-1:0]     digits_left_r, digits_left_nxt;

  always_comb begin
    logic              kvld;
    logic [4:0]        kcode;
    logic              nvld;
    logic [15:0]       nval;
    logic [LW-1:0]     left;
    logic [LW+1:0]     slot;
    logic [4:0]        dkey;
    logic signed [7:0] thr;

    kvld             = 1'b0;
    kcode            = '0;
    nvld             = 1'b0;
    nval             = '0;
    dkey             = {1'b0, cmd.key_digit};
    thr              = $signed({4'b0000, cfg.hold_threshold});
    held_key_vld_nxt = held_key_vld_r;
    held_key_nxt     = held_key_r;
    hold_ticks_nxt   = hold_ticks_r;
    entry_nxt        = entry_r;
    digits_left_nxt  = digits_left_r;

    // keypad key
    if (cmd.key_press) begin
      if (held_key_vld_nxt && (held_key_nxt == dkey)) begin
        hold_ticks_nxt = hold_ticks_nxt + 8'sd1;
      end else begin
        held_key_vld_nxt = 1'b1;
        held_key_nxt     = dkey;
        hold_ticks_nxt   = '0;
      end
      if (hold_ticks_nxt >= thr) begin
        hold_ticks_nxt = -$signed({1'b0, cfg.digit_repeat_delay});
        kvld           = 1'b1;
        kcode          = dkey;
      end
    end else if (cmd.release_hold) begin
      hold_ticks_nxt = '0;
    end

    // confirm key, after the keypad, same hold state
    if (cmd.confirm_press) begin
      if (held_key_vld_nxt && (held_key_nxt == CONFIRM_CODE)) begin
        hold_ticks_nxt = hold_ticks_nxt + 8'sd1;
      end else begin
        held_key_vld_nxt = 1'b1;
        held_key_nxt     = CONFIRM_CODE;
        hold_ticks_nxt   = '0;
      end
      if (hold_ticks_nxt >= thr) begin
        hold_ticks_nxt = -$signed({1'b0, cfg.confirm_repeat_delay});
        kvld           = 1'b1;
        kcode          = CONFIRM_CODE;
      end
    end

    // number entry
    left = digits_left_r;
    if ((left == '0) || (left > DIGITS)) begin
      left = DIGITS;
    end
    slot = '0;
    if (kvld) begin
      if (kcode != CONFIRM_CODE) begin
        // digit lands in slot left-1 counted from the bottom nibble
        slot = {2'b00, left - 1'b1};
        if (slot < SLOT_LIMIT) begin
          entry_nxt = entry_r + ({12'h000, kcode[3:0]} << {slot, 2'b00});
        end
        left = left - 1'b1;
        if (left == '0) begin
          nvld = 1'b1;
          nval = entry_nxt;
        end
      end else begin
        // early confirm: right-justify what was typed
        slot = {2'b00, left};
        nvld = 1'b1;
        if (slot < SLOT_LIMIT) begin
          nval = entry_r >> {slot, 2'b00};
        end
        left = '0;
      end
      if (left == '0) begin
        entry_nxt = '0;
        left      = DIGITS;
      end
      digits_left_nxt = left;
    end

    result.column_drive = cmd.column_drive;
    result.key_valid    = kvld;
    result.key_code     = kcode;
    result.number_valid = nvld;
    result.number_value = nval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_key_vld_r <= 1'b0;
      held_key_r     <= '0;
      hold_ticks_r   <= '0;
      entry_r        <= '0;
      digits_left_r  <= DIGITS;
    end else if (fire) begin
      held_key_vld_r <= held_key_vld_nxt;
      held_key_r     <= held_key_nxt;
      hold_ticks_r   <= hold_ticks_nxt;
      entry_r        <= entry_nxt;
      digits_left_r  <= digits_left_nxt;
    end
  end

endmodule

/* design/hex_keypad_scan_entry_top.sv */
// ----------------------------------------------------------------------------
// hex_keypad_scan_entry_top
// 4x4 hex keypad scanner with confirm key, hold qualification, auto-repeat
// and 4-digit hex number entry.
// ----------------------------------------------------------------------------
//
//  channel | ports                                    | item
//  --------+------------------------------------------+---------------------
//  input   | push, full, in_item                      | one scan tick
//  result  | pop, empty, out_item                     | one result per tick
//  config  | psel, penable, pwrite, paddr, pwdata,    | 3 registers at 0x0,
//          | prdata, pready                           | 0x4, 0x8
//
//  One item per clock sustained while the result queue is popped. An item
//  is classified in the front end on the accept edge, sits in a 2-entry
//  command queue, is worked off by the back end and lands in a 2-entry
//  result queue; empty goes low once that result is written. full rises
//  only when both queues back up under a stalled pop. rst_n is synchronous,
//  active low; registers return to 2, 20 and 100; hold/entry state clears.
//
module hex_keypad_scan_entry_top #(
  parameter int unsigned NUMBER_DIGITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // input queue side
  input  logic                push,
  output logic                full,
  input  hkse_pkg::in_item_t  in_item,
  // result queue side
  input  logic                pop,
  output logic                empty,
  output hkse_pkg::out_item_t out_item,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hkse_pkg::*;

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned OUT_W = $bits(out_item_t);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_threshold       <= HOLD_THRESHOLD_RST;
      cfg_r.digit_repeat_delay   <= DIGIT_REPEAT_DELAY_RST;
      cfg_r.confirm_repeat_delay <= CONFIRM_REPEAT_DELAY_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HOLD_THRESHOLD:       cfg_r.hold_threshold       <= pwdata[3:0];
        REG_DIGIT_REPEAT_DELAY:   cfg_r.digit_repeat_delay   <= pwdata[6:0];
        REG_CONFIRM_REPEAT_DELAY: cfg_r.confirm_repeat_delay <= pwdata[6:0];
        default: ;  // no register there
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HOLD_THRESHOLD:       prdata = {28'h0, cfg_r.hold_threshold};
      REG_DIGIT_REPEAT_DELAY:   prdata = {25'h0, cfg_r.digit_repeat_delay};
      REG_CONFIRM_REPEAT_DELAY: prdata = {25'h0, cfg_r.confirm_repeat_delay};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: column tracking and key classification
  // --------------------------------------------------------------------------
  logic       in_accept;
  cmd_t       front_cmd;

  assign in_accept = push && !full;

  hkse_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_item),
    .cmd    (front_cmd)
  );

  // --------------------------------------------------------------------------
  // Command queue between front and back
  // --------------------------------------------------------------------------
  logic             cmdq_empty;
  logic [CMD_W-1:0] cmdq_data;
  cmd_t             back_cmd;
  logic             back_fire;
  logic             resq_full;

  hkse_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_accept),
    .wr_data (front_cmd),
    .full    (full),
    .pop     (back_fire),
    .rd_data (cmdq_data),
    .empty   (cmdq_empty)
  );

  assign back_cmd  = cmd_t'(cmdq_data);
  // back end takes a command whenever the result queue has room
  assign back_fire = !cmdq_empty && !resq_full;

  // --------------------------------------------------------------------------
  // Back end: hold/repeat qualification and number entry
  // --------------------------------------------------------------------------
  out_item_t back_result;

  hkse_back #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (back_fire),
    .cmd    (back_cmd),
    .cfg    (cfg_r),
    .result (back_result)
  );

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0] resq_data;

  hkse_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (back_fire),
    .wr_data (back_result),
    .full    (resq_full),
    .pop     (pop),
    .rd_data (resq_data),
    .empty   (empty)
  );

  assign out_item = out_item_t'(resq_data);

endmodule
